/* design/vrra_pkg.sv */
// Package: constants, codes and types of the variable-record ring allocator.
package vrra_pkg;

   localparam int MAX_RECORDS_DEF      = 64;
   localparam int MAX_BUFFER_BYTES_DEF = 65536;

   localparam int KIND_W   = 3;
   localparam int BYTES_W  = 17;
   localparam int OFFSET_W = 16;
   localparam int COUNT_W  = 7;
   localparam int INDEX_W  = 6;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W    = BYTES_W + 2;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK_F = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK_B = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LIMIT = 2'd1;

   typedef struct packed {
      logic [BYTES_W-1:0] offset;
      logic [BYTES_W-1:0] size;
   } slot_type;

endpackage

/* design/variable_record_ring_allocator.sv */
// Variable-record ring allocator: descriptor ring, placement sequencer and free-space report.
// Busy drops as the strobe rises, so the next item is taken at the edge that ends the result
// cycle. The single descriptor memory read port fetches the oldest and newest descriptors
// one per cycle through one shared slot address adder.
// Strobe high one cycle, never stalled; synchronous reset empties the ring, loads defaults.
module variable_record_ring_allocator #(
   parameter int MAX_RECORDS      = vrra_pkg::MAX_RECORDS_DEF,
   parameter int MAX_BUFFER_BYTES = vrra_pkg::MAX_BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [vrra_pkg::KIND_W-1:0]     req_kind,
   input  logic [vrra_pkg::BYTES_W-1:0]    req_record_bytes,
   input  logic                            req_evict_to_fit,
   input  logic [vrra_pkg::INDEX_W-1:0]    req_peek_index,
   output logic                            rsp_valid,
   output logic                            rsp_ok,
   output logic [vrra_pkg::OFFSET_W-1:0]   rsp_offset,
   output logic [vrra_pkg::BYTES_W-1:0]    rsp_record_size,
   output logic [vrra_pkg::COUNT_W-1:0]    rsp_evicted,
   output logic [vrra_pkg::COUNT_W-1:0]    rsp_stored_records,
   output logic [vrra_pkg::BYTES_W-1:0]    rsp_free_bytes,
   input  logic                            csr_we,
   input  logic [vrra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vrra_pkg::BYTES_W-1:0]    csr_wdata
);
   import vrra_pkg::*;

   localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int LIM_RST = (MAX_RECORDS < 64) ? MAX_RECORDS : 64;
   localparam int BUF_RST = (MAX_BUFFER_BYTES < 65536) ? MAX_BUFFER_BYTES : 65536;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE        = 4'd0;
   localparam logic [ST_W-1:0] S_PUSH_CHECK  = 4'd1;
   localparam logic [ST_W-1:0] S_DROP        = 4'd2;
   localparam logic [ST_W-1:0] S_FETCH_FIRST = 4'd3;
   localparam logic [ST_W-1:0] S_FETCH_LAST  = 4'd4;
   localparam logic [ST_W-1:0] S_EVAL        = 4'd5;
   localparam logic [ST_W-1:0] S_READ_ONE    = 4'd6;
   localparam logic [ST_W-1:0] S_TAKE_ONE    = 4'd7;
   localparam logic [ST_W-1:0] S_FREE_START  = 4'd8;

   slot_type mem [MAX_RECORDS];

   logic [ST_W-1:0]    state_ff, state_in;
   logic               phase_free_ff, phase_free_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [BYTES_W-1:0] size_ff, size_in;
   logic               evict_ff, evict_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [IW-1:0]      oldest_ff, oldest_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lim_ff, lim_in;
   logic [BYTES_W-1:0] buf_ff, buf_in;
   logic [CW-1:0]      evicted_ff, evicted_in;
   logic               ok_ff, ok_in;
   logic [BYTES_W-1:0] off_ff, off_in;
   logic [BYTES_W-1:0] rsize_ff, rsize_in;
   slot_type           first_ff, first_in;
   slot_type           rd_ff;

   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [BYTES_W-1:0] rsp_size_ff;
   logic [COUNT_W-1:0] rsp_evicted_ff;
   logic [COUNT_W-1:0] rsp_stored_ff;
   logic [BYTES_W-1:0] rsp_free_ff;

   logic [CW-1:0]      k_sel;
   logic [CW:0]        slot_sum;
   logic [IW-1:0]      slot;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   slot_type           wr_data;
   logic               emit;
   logic [BYTES_W-1:0] free_val;
   logic [CW-1:0]      lim_cfg;
   logic [BYTES_W-1:0] buf_cfg;

   logic [SUM_W-1:0]   fo, lo_s, start_s, end_s, buf_s, sz_s, tail_s, free_s;
   logic               fit_after, fit_front, wrapped;

   // shared slot address unit: (oldest + k) mod limit
   always_comb begin
      k_sel = '0;
      case (state_ff)
         S_DROP:       k_sel = CW'(1);
         S_FETCH_LAST: k_sel = count_ff - CW'(1);
         S_EVAL:       k_sel = count_ff;
         S_TAKE_ONE:   k_sel = CW'(1);
         S_READ_ONE: begin
            if (kind_ff == KIND_PEEK_F) begin
               k_sel = CW'(idx_ff);
            end else if (kind_ff == KIND_PEEK_B) begin
               k_sel = CW'(32'(count_ff) - 32'd1 - 32'(idx_ff));
            end
         end
         default:      k_sel = '0;
      endcase
      slot_sum = {1'b0, CW'(oldest_ff)} + {1'b0, k_sel};
      if (slot_sum >= {1'b0, lim_ff}) begin
         slot = IW'(slot_sum - {1'b0, lim_ff});
      end else begin
         slot = IW'(slot_sum);
      end
   end

   always_comb begin
      if (csr_wdata[COUNT_W-1:0] == '0) begin
         lim_cfg = CW'(1);
      end else if (32'(csr_wdata[COUNT_W-1:0]) > 32'(MAX_RECORDS)) begin
         lim_cfg = CW'(MAX_RECORDS);
      end else begin
         lim_cfg = CW'(csr_wdata[COUNT_W-1:0]);
      end
      if (csr_wdata == '0) begin
         buf_cfg = BYTES_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_BUFFER_BYTES)) begin
         buf_cfg = BYTES_W'(MAX_BUFFER_BYTES);
      end else begin
         buf_cfg = csr_wdata;
      end
   end

   // placement and free-space compare, first from first_ff, last from rd_ff
   always_comb begin
      fo        = SUM_W'(first_ff.offset);
      lo_s      = SUM_W'(rd_ff.offset);
      start_s   = lo_s + SUM_W'(rd_ff.size);
      sz_s      = SUM_W'(size_ff);
      end_s     = start_s + sz_s;
      buf_s     = SUM_W'(buf_ff);
      wrapped   = lo_s < fo;
      fit_after = (start_s < buf_s) && (end_s <= buf_s) && ((fo < start_s) || (end_s <= fo));
      fit_front = !wrapped && (sz_s <= fo);
      tail_s    = (start_s <= buf_s) ? buf_s - start_s : '0;
      if (wrapped) begin
         free_s = (start_s <= fo) ? fo - start_s : '0;
      end else begin
         free_s = (tail_s > fo) ? tail_s : fo;
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_free_in = phase_free_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      evict_in      = evict_ff;
      idx_in        = idx_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      lim_in        = lim_ff;
      buf_in        = buf_ff;
      evicted_in    = evicted_ff;
      ok_in         = ok_ff;
      off_in        = off_ff;
      rsize_in      = rsize_ff;
      first_in      = first_ff;
      wr_en         = 1'b0;
      wr_addr       = slot;
      wr_data       = '{offset: '0, size: size_ff};
      emit          = 1'b0;
      free_val      = buf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               if (csr_index == CSR_BUFFER_BYTES) begin
                  buf_in    = buf_cfg;
                  oldest_in = '0;
                  count_in  = '0;
               end else if (csr_index == CSR_RECORD_LIMIT) begin
                  lim_in    = lim_cfg;
                  oldest_in = '0;
                  count_in  = '0;
               end
            end else if (start) begin
               kind_in    = req_kind;
               size_in    = req_record_bytes;
               evict_in   = req_evict_to_fit;
               idx_in     = req_peek_index;
               evicted_in = '0;
               ok_in      = 1'b0;
               off_in     = '0;
               rsize_in   = '0;
               state_in   = S_FREE_START;
               case (req_kind) inside
                  KIND_PUSH: begin
                     if (req_record_bytes <= buf_ff) begin
                        state_in = S_PUSH_CHECK;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff != '0) begin
                        state_in = S_READ_ONE;
                     end
                  end
                  KIND_PEEK_F, KIND_PEEK_B: begin
                     if (32'(req_peek_index) < 32'(count_ff)) begin
                        state_in = S_READ_ONE;
                     end
                  end
                  KIND_CLEAR: begin
                     oldest_in = '0;
                     count_in  = '0;
                     ok_in     = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_PUSH_CHECK: begin
            if (count_ff == '0) begin
               wr_en     = 1'b1;
               wr_addr   = '0;
               oldest_in = '0;
               count_in  = CW'(1);
               ok_in     = 1'b1;
               off_in    = '0;
               rsize_in  = size_ff;
               state_in  = S_FREE_START;
            end else if (count_ff < lim_ff) begin
               phase_free_in = 1'b0;
               state_in      = S_FETCH_FIRST;
            end else if (evict_ff) begin
               state_in = S_DROP;
            end else begin
               state_in = S_FREE_START;
            end
         end
         S_DROP: begin
            oldest_in  = slot;
            count_in   = count_ff - CW'(1);
            evicted_in = evicted_ff + CW'(1);
            state_in   = S_PUSH_CHECK;
         end
         S_FETCH_FIRST: begin
            state_in = S_FETCH_LAST;
         end
         S_FETCH_LAST: begin
            first_in = rd_ff;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (phase_free_ff) begin
               emit     = 1'b1;
               free_val = BYTES_W'(free_s);
               state_in = S_IDLE;
            end else if (fit_after || fit_front) begin
               wr_en          = 1'b1;
               wr_data.offset = fit_after ? BYTES_W'(start_s) : '0;
               off_in         = wr_data.offset;
               rsize_in       = size_ff;
               ok_in          = 1'b1;
               count_in       = count_ff + CW'(1);
               state_in       = S_FREE_START;
            end else if (evict_ff) begin
               state_in = S_DROP;
            end else begin
               state_in = S_FREE_START;
            end
         end
         S_READ_ONE: begin
            state_in = S_TAKE_ONE;
         end
         S_TAKE_ONE: begin
            ok_in    = 1'b1;
            off_in   = rd_ff.offset;
            rsize_in = rd_ff.size;
            if (kind_ff == KIND_POP) begin
               oldest_in = slot;
               count_in  = count_ff - CW'(1);
            end
            state_in = S_FREE_START;
         end
         S_FREE_START: begin
            if (count_ff == '0) begin
               emit     = 1'b1;
               free_val = buf_ff;
               state_in = S_IDLE;
            end else begin
               phase_free_in = 1'b1;
               state_in      = S_FETCH_FIRST;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // descriptor memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         lim_ff       <= CW'(LIM_RST);
         buf_ff       <= BYTES_W'(BUF_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         lim_ff       <= lim_in;
         buf_ff       <= buf_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      phase_free_ff <= phase_free_in;
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      evict_ff      <= evict_in;
      idx_ff        <= idx_in;
      evicted_ff    <= evicted_in;
      ok_ff         <= ok_in;
      off_ff        <= off_in;
      rsize_ff      <= rsize_in;
      first_ff      <= first_in;
      if (emit) begin
         rsp_ok_ff      <= ok_ff;
         rsp_offset_ff  <= OFFSET_W'(off_ff);
         rsp_size_ff    <= rsize_ff;
         rsp_evicted_ff <= COUNT_W'(evicted_ff);
         rsp_stored_ff  <= COUNT_W'(count_ff);
         rsp_free_ff    <= free_val;
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_offset         = rsp_offset_ff;
   assign rsp_record_size    = rsp_size_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_stored_records = rsp_stored_ff;
   assign rsp_free_bytes     = rsp_free_ff;

endmodule
